// File: design/dht_pkg.sv
`default_nettype none

package dht_pkg;

  localparam int unsigned DHT_TABLE_SIZE = 16;
  localparam int unsigned DHT_STEP_PRIME = 7;
  localparam int unsigned DHT_KEY_W      = 31;
  localparam int unsigned DHT_SLOT_W     = 4;
  localparam int unsigned DHT_STATUS_W   = 3;
  localparam int unsigned DHT_PROBE_W    = 5;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_SEARCH = 1'b1
  } dht_req_e;

  typedef enum logic [DHT_STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_ZERO_KEY  = 3'd4
  } dht_status_e;

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_MOD,
    FSM_STEP,
    FSM_PROBE,
    FSM_DONE
  } dht_state_e;

  typedef struct packed {
    dht_req_e               req_type;
    logic [DHT_KEY_W-1:0]   key;
  } dht_req_t;

  typedef struct packed {
    logic [DHT_SLOT_W-1:0]  slot_index;
    dht_status_e            status;
    logic [DHT_PROBE_W-1:0] probe_count;
  } dht_rsp_t;

endpackage

`default_nettype wire

// File: design/dht_mod.sv
`default_nettype none

// Remainder by a constant: reciprocal multiply, then one compare and subtract.
module dht_mod import dht_pkg::*; #(
  parameter int unsigned VAL_W = DHT_KEY_W,
  parameter int unsigned MOD   = DHT_TABLE_SIZE
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [VAL_W-1:0]         value_i,
  output logic                          done_o,
  output logic [$clog2(MOD)-1:0]        rem_o
);

  localparam int unsigned RW    = $clog2(MOD);
  localparam int unsigned SH    = VAL_W + RW;
  localparam int unsigned PRD_W = 2 * VAL_W + 1;
  localparam logic [VAL_W:0] RECIP = (VAL_W+1)'((64'd1 << SH) / 64'(MOD));
  localparam logic [RW:0]    MODV  = (RW+1)'(MOD);

  logic              pend_q, pend_d;
  logic              done_q, done_d;
  logic [RW:0]       lo_q, lo_d;
  logic [RW:0]       quo_q, quo_d;
  logic [RW-1:0]     rem_q, rem_d;
  logic [PRD_W-1:0]  prod;
  logic [RW:0]       qm;
  logic [RW:0]       diff;

  // quotient estimate is exact or one low, so the raw remainder is below 2*MOD
  assign prod = value_i * RECIP;
  assign qm   = quo_q * MODV;
  assign diff = lo_q - qm;

  always_comb begin
    pend_d = start_i;
    done_d = pend_q;
    lo_d   = lo_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      lo_d  = (RW+1)'(value_i);
      quo_d = (RW+1)'(prod >> SH);
    end
    if (pend_q) begin
      rem_d = (diff >= MODV) ? RW'(diff - MODV) : diff[RW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// File: design/double_hash_table.sv
`default_nettype none

// Channel  Dir  Valid        Stall        Data
// request  in   in_valid_i   in_stall_o   in_data_i  (dht_req_t)
// result   out  out_valid_o  out_stall_i  out_data_o (dht_rsp_t)
//
// Per item, from one request transfer to the next: the key reductions, the step
// reduction, one slot read per probe on the single table RAM, then the result.
// A new request is taken only once the block is back in idle.
// Zero key: no reductions or probes. After reset the table is cleared, stalled.
// A result waiting in the output register does not block the next request.
module double_hash_table import dht_pkg::*; #(
  parameter int unsigned TABLE_SIZE = DHT_TABLE_SIZE,
  parameter int unsigned STEP_PRIME = DHT_STEP_PRIME
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire dht_req_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output dht_rsp_t      out_data_o
);

  localparam int unsigned SW  = $clog2(TABLE_SIZE);
  localparam int unsigned CW  = $clog2(TABLE_SIZE + 1);
  localparam int unsigned PRW = $clog2(STEP_PRIME);
  localparam int unsigned PW  = $clog2(STEP_PRIME + 1);
  localparam logic [SW:0]    TSV  = (SW+1)'(TABLE_SIZE);
  localparam logic [CW-1:0]  TCV  = CW'(TABLE_SIZE);
  localparam logic [SW-1:0]  TLST = SW'(TABLE_SIZE - 1);
  localparam logic [PW-1:0]  PV   = PW'(STEP_PRIME);

  dht_state_e            state_q, state_d;
  logic [DHT_KEY_W-1:0]  key_q, key_d;
  logic                  search_q, search_d;
  logic [SW-1:0]         cur_q, cur_d;
  logic [CW-1:0]         probe_q, probe_d;
  logic [SW-1:0]         clr_q, clr_d;
  dht_rsp_t              res_q, res_d;
  logic                  out_valid_q, out_valid_d;
  dht_rsp_t              out_q, out_d;

  logic [DHT_KEY_W-1:0]  mem [TABLE_SIZE];
  logic [DHT_KEY_W-1:0]  rd_q;
  logic                  mem_we;
  logic [SW-1:0]         mem_wa;
  logic [DHT_KEY_W-1:0]  mem_wd;

  logic                  in_xfer;
  logic                  key_zero;
  logic                  hash_start;
  logic                  tmod_done, pmod_done, smod_done;
  logic [SW-1:0]         tmod_rem, smod_rem;
  logic [PRW-1:0]        pmod_rem;
  logic [PW-1:0]         step_val;
  logic                  step_start;
  logic [SW:0]           slot_sum;
  logic [SW-1:0]         nxt_slot;
  logic [CW-1:0]         probe_n;
  logic                  hit, empty, last;
  logic                  out_load;

  assign in_stall_o = (state_q != FSM_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign key_zero   = (in_data_i.key == '0);
  assign hash_start = in_xfer && !key_zero;
  assign step_val   = PV - PW'(pmod_rem);
  assign step_start = (state_q == FSM_MOD) && tmod_done;

  dht_mod #(.VAL_W(DHT_KEY_W), .MOD(TABLE_SIZE)) u_tmod (
    .clk_i, .rst_ni, .start_i(hash_start), .value_i(in_data_i.key),
    .done_o(tmod_done), .rem_o(tmod_rem)
  );

  dht_mod #(.VAL_W(DHT_KEY_W), .MOD(STEP_PRIME)) u_pmod (
    .clk_i, .rst_ni, .start_i(hash_start), .value_i(in_data_i.key),
    .done_o(pmod_done), .rem_o(pmod_rem)
  );

  // probe step reduced below TABLE_SIZE so each advance is one add and compare
  dht_mod #(.VAL_W(PW), .MOD(TABLE_SIZE)) u_smod (
    .clk_i, .rst_ni, .start_i(step_start), .value_i(step_val),
    .done_o(smod_done), .rem_o(smod_rem)
  );

  assign slot_sum = {1'b0, cur_q} + {1'b0, smod_rem};
  assign nxt_slot = (slot_sum >= TSV) ? SW'(slot_sum - TSV) : slot_sum[SW-1:0];
  assign probe_n  = probe_q + 1'b1;
  assign hit      = (rd_q == key_q);
  assign empty    = (rd_q == '0);
  assign last     = (probe_n == TCV);
  assign out_load = (state_q == FSM_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_CLEAR: begin
        if (clr_q == TLST) state_d = FSM_IDLE;
      end
      FSM_IDLE: begin
        if (in_xfer) state_d = key_zero ? FSM_DONE : FSM_MOD;
      end
      FSM_MOD: begin
        if (tmod_done) state_d = FSM_STEP;
      end
      FSM_STEP: begin
        if (smod_done) state_d = FSM_PROBE;
      end
      FSM_PROBE: begin
        if (empty || (search_q && hit) || last) state_d = FSM_DONE;
      end
      FSM_DONE: begin
        if (out_load) state_d = FSM_IDLE;
      end
      default: state_d = FSM_CLEAR;
    endcase
  end

  always_comb begin
    key_d       = key_q;
    search_d    = search_q;
    cur_d       = cur_q;
    probe_d     = probe_q;
    clr_d       = clr_q;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_wa      = cur_q;
    mem_wd      = key_q;
    out_d       = out_load ? res_q : out_q;
    out_valid_d = out_load || (out_valid_q && out_stall_i);
    case (state_q)
      FSM_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
        clr_d  = clr_q + 1'b1;
      end
      FSM_IDLE: begin
        if (in_xfer) begin
          key_d    = in_data_i.key;
          search_d = (in_data_i.req_type == REQ_SEARCH);
          res_d    = '{slot_index: '0, status: ST_ZERO_KEY, probe_count: '0};
        end
      end
      FSM_STEP: begin
        cur_d   = tmod_rem;
        probe_d = '0;
      end
      FSM_PROBE: begin
        if (search_q && hit) begin
          res_d = '{slot_index: DHT_SLOT_W'(cur_q), status: ST_FOUND,
                    probe_count: DHT_PROBE_W'(probe_n)};
        end else if (search_q && empty) begin
          res_d = '{slot_index: '0, status: ST_NOT_FOUND,
                    probe_count: DHT_PROBE_W'(probe_n)};
        end else if (empty) begin
          mem_we = 1'b1;
          res_d  = '{slot_index: DHT_SLOT_W'(cur_q), status: ST_INSERTED,
                     probe_count: DHT_PROBE_W'(probe_n)};
        end else if (last) begin
          res_d = '{slot_index: '0, status: search_q ? ST_NOT_FOUND : ST_FULL,
                    probe_count: DHT_PROBE_W'(probe_n)};
        end else begin
          cur_d   = nxt_slot;
          probe_d = probe_n;
        end
      end
      default: ;
    endcase
  end

  // table RAM, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[cur_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    search_q <= search_d;
    cur_q    <= cur_d;
    probe_q  <= probe_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_write_empty_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_PROBE && mem_we) |-> (rd_q == '0))
    else $error("insert overwrote an occupied slot");

  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_PROBE) |-> (probe_q < TCV))
    else $error("probe count ran past table size");

  a_mods_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tmod_done |-> pmod_done)
    else $error("key reductions out of step");

  a_slot_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_INSERTED && out_data_o.status != ST_FOUND)
      |-> (out_data_o.slot_index == '0))
    else $error("slot index set on failed request");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_PROBE || state_q == FSM_MOD) |-> in_stall_o)
    else $error("request taken while busy");

endmodule

`default_nettype wire
